FILE: src/ck2d_pkg.sv
// Shared constants for the cubic spline kernel core: config indexes and scale reset values.
package ck2d_pkg;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_H      = 2'd0,
    CFG_KERNEL_SC  = 2'd1,
    CFG_GRAD_SC    = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  // Reset values of the scale registers, given in Q8.16.
  localparam longint KS_RST_Q16 = 22343;
  localparam longint GS_RST_Q16 = 67030;  // magnitude; the register resets to its negative

endpackage

FILE: src/sph_cubic_kernel_2d_core.sv
// Top level of the 2D cubic spline kernel core: pipelined distance, kernel value and gradient.
//
// The core accepts one displacement (dx, dy) per cycle and returns the kernel value W,
// the gradient (grad_x, grad_y) and two flags for every transaction, in order. The
// absolute values, the squares and their sum form the squared distance, one pipeline
// stage per root bit takes the square root (COORD_WIDTH stages), one stage per
// quotient bit forms the unit vector (FRAC_BITS + 1 stages), and eight stages evaluate the
// spline, scale it and saturate. The whole pipeline advances together; it holds only while
// a result sits in the output register and out_ready is low, so with out_ready high the
// throughput is one transaction per clock. Configuration writes take effect at once and are
// meant to be made while no transaction is in flight.
module sph_cubic_kernel_2d_core
  import ck2d_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration port.
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata,
  // Input channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_dx,
  input  logic signed [COORD_WIDTH-1:0] in_dy,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_WIDTH-1:0]        out_kernel_value,
  output logic signed [COORD_WIDTH-1:0] out_grad_x,
  output logic signed [COORD_WIDTH-1:0] out_grad_y,
  output logic                          out_outside_support,
  output logic                          out_saturated
);

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int QW = 2*W - F;

  localparam int KS_SH = (F >= 16) ? F - 16 : 16 - F;
  localparam longint KS_RST = (F >= 16) ? (KS_RST_Q16 << KS_SH) : (KS_RST_Q16 >> KS_SH);
  localparam longint GS_RST = (F >= 16) ? (GS_RST_Q16 << KS_SH) : (GS_RST_Q16 >> KS_SH);

  localparam logic [F+1:0] ONE_Q = (F+2)'(1) << F;
  localparam logic [F+1:0] TWO_Q = (F+2)'(1) << (F+1);
  localparam logic [QW-1:0] TWO_QW = QW'(1) << (F+1);

  // Configuration registers.
  logic [W-1:0] inv_h_r;
  logic [W-1:0] kscale_r;
  logic [W-1:0] gscale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_h_r  <= W'(1) << F;
      kscale_r <= W'(KS_RST);
      gscale_r <= W'(-GS_RST);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INV_H:     inv_h_r  <= cfg_wdata;
        CFG_KERNEL_SC: kscale_r <= cfg_wdata;
        CFG_GRAD_SC:   gscale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline advances unless the output register holds an untaken result.
  logic en;
  logic k8_v_r;
  assign en       = !k8_v_r || out_ready;
  assign in_ready = en;

  // Stage 1: absolute values and signs.
  logic         s1_v_r;
  logic [W-1:0] s1_ax_r, s1_ay_r;
  logic         s1_sx_r, s1_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_valid;
    if (en) begin
      s1_ax_r <= in_dx[W-1] ? (~in_dx + W'(1)) : in_dx;
      s1_ay_r <= in_dy[W-1] ? (~in_dy + W'(1)) : in_dy;
      s1_sx_r <= in_dx[W-1];
      s1_sy_r <= in_dy[W-1];
    end
  end

  // Stage 2: squares of both components.
  logic           s2_v_r;
  logic [2*W-1:0] s2_xx_r, s2_yy_r;
  logic [W-1:0]   s2_ax_r, s2_ay_r;
  logic           s2_sx_r, s2_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
    if (en) begin
      s2_xx_r <= s1_ax_r * s1_ax_r;
      s2_yy_r <= s1_ay_r * s1_ay_r;
      s2_ax_r <= s1_ax_r;
      s2_ay_r <= s1_ay_r;
      s2_sx_r <= s1_sx_r;
      s2_sy_r <= s1_sy_r;
    end
  end

  // Square root pipeline; entry 0 holds the squared distance.
  logic           sq_v_r    [0:W];
  logic [2*W-1:0] sq_n_r    [0:W];
  logic [W+1:0]   sq_rem_r  [0:W];
  logic [W-1:0]   sq_root_r [0:W];
  logic [W-1:0]   sq_ax_r   [0:W];
  logic [W-1:0]   sq_ay_r   [0:W];
  logic           sq_sx_r   [0:W];
  logic           sq_sy_r   [0:W];

  // Stage 3: squared distance; the sum of two squares stays below 2^(2W).
  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (en) sq_v_r[0] <= s2_v_r;
    if (en) begin
      sq_n_r[0]    <= s2_xx_r + s2_yy_r;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_ax_r[0]   <= s2_ax_r;
      sq_ay_r[0]   <= s2_ay_r;
      sq_sx_r[0]   <= s2_sx_r;
      sq_sy_r[0]   <= s2_sy_r;
    end
  end

  // One root bit per stage, most significant first.
  for (genvar k = 0; k < W; k++) begin : g_sqrt
    localparam int HI = 2*(W-1-k) + 1;
    logic [W+3:0] rem_s, trial, diff;
    logic [W+1:0] rem_nxt;
    logic [W-1:0] root_nxt;

    always_comb begin
      rem_s = {sq_rem_r[k], sq_n_r[k][HI], sq_n_r[k][HI-1]};
      trial = {2'b00, sq_root_r[k], 2'b01};
      diff  = rem_s - trial;
      if (rem_s >= trial) begin
        rem_nxt  = diff[W+1:0];
        root_nxt = {sq_root_r[k][W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_s[W+1:0];
        root_nxt = {sq_root_r[k][W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[k+1] <= 1'b0;
      else if (en) sq_v_r[k+1] <= sq_v_r[k];
      if (en) begin
        sq_n_r[k+1]    <= sq_n_r[k];
        sq_rem_r[k+1]  <= rem_nxt;
        sq_root_r[k+1] <= root_nxt;
        sq_ax_r[k+1]   <= sq_ax_r[k];
        sq_ay_r[k+1]   <= sq_ay_r[k];
        sq_sx_r[k+1]   <= sq_sx_r[k];
        sq_sy_r[k+1]   <= sq_sy_r[k];
      end
    end
  end

  // Unit vector division: since |dx| <= r, the quotient has F+1 bits and the
  // partial remainder starts at |dx| itself.
  logic         dv_v_r  [0:F];
  logic [W-1:0] dv_r_r  [0:F];
  logic [W-1:0] dv_rx_r [0:F];
  logic [W-1:0] dv_ry_r [0:F];
  logic [F:0]   dv_qx_r [0:F];
  logic [F:0]   dv_qy_r [0:F];
  logic         dv_sx_r [0:F];
  logic         dv_sy_r [0:F];

  for (genvar j = 0; j <= F; j++) begin : g_div
    logic         v_in, sx_in, sy_in;
    logic [W-1:0] r_in, rx_in, ry_in;
    logic [F:0]   qx_in, qy_in;
    logic [W:0]   shx, shy, dfx, dfy;
    logic         gex, gey;

    if (j == 0) begin : g_first
      assign v_in  = sq_v_r[W];
      assign r_in  = sq_root_r[W];
      assign rx_in = sq_ax_r[W];
      assign ry_in = sq_ay_r[W];
      assign qx_in = '0;
      assign qy_in = '0;
      assign sx_in = sq_sx_r[W];
      assign sy_in = sq_sy_r[W];
      assign shx   = {1'b0, rx_in};
      assign shy   = {1'b0, ry_in};
    end else begin : g_next
      assign v_in  = dv_v_r[j-1];
      assign r_in  = dv_r_r[j-1];
      assign rx_in = dv_rx_r[j-1];
      assign ry_in = dv_ry_r[j-1];
      assign qx_in = dv_qx_r[j-1];
      assign qy_in = dv_qy_r[j-1];
      assign sx_in = dv_sx_r[j-1];
      assign sy_in = dv_sy_r[j-1];
      assign shx   = {rx_in, 1'b0};
      assign shy   = {ry_in, 1'b0};
    end

    assign gex = shx >= {1'b0, r_in};
    assign gey = shy >= {1'b0, r_in};
    assign dfx = shx - {1'b0, r_in};
    assign dfy = shy - {1'b0, r_in};

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j] <= 1'b0;
      else if (en) dv_v_r[j] <= v_in;
      if (en) begin
        dv_r_r[j]  <= r_in;
        dv_rx_r[j] <= gex ? dfx[W-1:0] : shx[W-1:0];
        dv_ry_r[j] <= gey ? dfy[W-1:0] : shy[W-1:0];
        dv_qx_r[j] <= {qx_in[F-1:0], gex};
        dv_qy_r[j] <= {qy_in[F-1:0], gey};
        dv_sx_r[j] <= sx_in;
        dv_sy_r[j] <= sy_in;
      end
    end
  end

  // K1: q = r / h, and the signed unit components.
  logic             k1_v_r;
  logic [QW-1:0]    k1_q_r;
  logic signed [F+1:0] k1_ux_r, k1_uy_r;
  logic [2*W-1:0]   qprod;
  logic signed [F+1:0] ux_pos, uy_pos;

  assign qprod  = dv_r_r[F] * inv_h_r;
  assign ux_pos = $signed({1'b0, dv_qx_r[F]});
  assign uy_pos = $signed({1'b0, dv_qy_r[F]});

  always_ff @(posedge clk) begin
    if (!rst_n) k1_v_r <= 1'b0;
    else if (en) k1_v_r <= dv_v_r[F];
    if (en) begin
      k1_q_r  <= qprod[2*W-1:F];
      k1_ux_r <= dv_sx_r[F] ? -ux_pos : ux_pos;
      k1_uy_r <= dv_sy_r[F] ? -uy_pos : uy_pos;
    end
  end

  // K2: support test and the terms 2-q and |1-q|.
  logic             k2_v_r, k2_out_r, k2_lt1_r, k2_nz_r;
  logic [F+1:0]     k2_a_r;
  logic [F:0]       k2_bm_r;
  logic signed [F+1:0] k2_ux_r, k2_uy_r;
  logic [F+1:0]     q_lo, bdiff_hi, bdiff_lo;

  assign q_lo     = k1_q_r[F+1:0];
  assign bdiff_hi = q_lo - ONE_Q;
  assign bdiff_lo = ONE_Q - q_lo;

  always_ff @(posedge clk) begin
    if (!rst_n) k2_v_r <= 1'b0;
    else if (en) k2_v_r <= k1_v_r;
    if (en) begin
      k2_out_r <= k1_q_r >= TWO_QW;
      k2_lt1_r <= q_lo < ONE_Q;
      k2_nz_r  <= k1_q_r != '0;
      k2_a_r   <= TWO_Q - q_lo;
      k2_bm_r  <= (q_lo >= ONE_Q) ? bdiff_hi[F:0] : bdiff_lo[F:0];
      k2_ux_r  <= k1_ux_r;
      k2_uy_r  <= k1_uy_r;
    end
  end

  // K3: squared terms.
  logic             k3_v_r, k3_out_r, k3_lt1_r, k3_nz_r;
  logic [F+1:0]     k3_a_r;
  logic [F:0]       k3_bm_r;
  logic [F+2:0]     k3_a2_r;
  logic [F:0]       k3_b2_r;
  logic signed [F+1:0] k3_ux_r, k3_uy_r;
  logic [2*F+3:0]   aa;
  logic [2*F+1:0]   bb;

  assign aa = k2_a_r * k2_a_r;
  assign bb = k2_bm_r * k2_bm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) k3_v_r <= 1'b0;
    else if (en) k3_v_r <= k2_v_r;
    if (en) begin
      k3_out_r <= k2_out_r;
      k3_lt1_r <= k2_lt1_r;
      k3_nz_r  <= k2_nz_r;
      k3_a_r   <= k2_a_r;
      k3_bm_r  <= k2_bm_r;
      k3_a2_r  <= aa[2*F+2:F];
      k3_b2_r  <= bb[2*F:F];
      k3_ux_r  <= k2_ux_r;
      k3_uy_r  <= k2_uy_r;
    end
  end

  // K4: cubed terms.
  logic             k4_v_r, k4_out_r, k4_lt1_r, k4_nz_r;
  logic [F+2:0]     k4_a2_r;
  logic [F:0]       k4_b2_r;
  logic [F+3:0]     k4_a3_r;
  logic [F:0]       k4_b3_r;
  logic signed [F+1:0] k4_ux_r, k4_uy_r;
  logic [2*F+4:0]   a2a;
  logic [2*F+1:0]   b2b;

  assign a2a = k3_a2_r * k3_a_r;
  assign b2b = k3_b2_r * k3_bm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) k4_v_r <= 1'b0;
    else if (en) k4_v_r <= k3_v_r;
    if (en) begin
      k4_out_r <= k3_out_r;
      k4_lt1_r <= k3_lt1_r;
      k4_nz_r  <= k3_nz_r;
      k4_a2_r  <= k3_a2_r;
      k4_b2_r  <= k3_b2_r;
      k4_a3_r  <= a2a[2*F+3:F];
      k4_b3_r  <= b2b[2*F:F];
      k4_ux_r  <= k3_ux_r;
      k4_uy_r  <= k3_uy_r;
    end
  end

  // K5: spline polynomial P (clamped at zero) and its slope term S.
  logic             k5_v_r, k5_out_r, k5_nz_r;
  logic [F+3:0]     k5_p_r;
  logic signed [F+4:0] k5_s_r;
  logic signed [F+1:0] k5_ux_r, k5_uy_r;
  logic signed [F+5:0] pd;
  logic signed [F+4:0] sd;

  always_comb begin
    pd = $signed({2'b00, k4_a3_r});
    sd = $signed({2'b00, k4_a2_r});
    if (k4_lt1_r) begin
      pd = pd - $signed({3'b000, k4_b3_r, 2'b00});
      sd = sd - $signed({2'b00, k4_b2_r, 2'b00});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) k5_v_r <= 1'b0;
    else if (en) k5_v_r <= k4_v_r;
    if (en) begin
      k5_out_r <= k4_out_r;
      k5_nz_r  <= k4_nz_r;
      k5_p_r   <= pd[F+5] ? '0 : pd[F+3:0];
      k5_s_r   <= sd;
      k5_ux_r  <= k4_ux_r;
      k5_uy_r  <= k4_uy_r;
    end
  end

  // K6: scale by C and by D.
  logic             k6_v_r, k6_out_r, k6_nz_r;
  logic [W+3:0]     k6_w_r;
  logic signed [W+4:0] k6_g_r;
  logic signed [F+1:0] k6_ux_r, k6_uy_r;
  logic [W+F+3:0]   wp;
  logic signed [W+F+4:0] gp;

  assign wp = kscale_r * k5_p_r;
  assign gp = $signed(gscale_r) * k5_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) k6_v_r <= 1'b0;
    else if (en) k6_v_r <= k5_v_r;
    if (en) begin
      k6_out_r <= k5_out_r;
      k6_nz_r  <= k5_nz_r;
      k6_w_r   <= wp[W+F+3:F];
      k6_g_r   <= gp[W+F+4:F];
      k6_ux_r  <= k5_ux_r;
      k6_uy_r  <= k5_uy_r;
    end
  end

  // K7: gradient components and kernel value saturation.
  logic             k7_v_r, k7_out_r, k7_nz_r, k7_wclip_r;
  logic [W-1:0]     k7_w_r;
  logic signed [W+6:0] k7_gx_r, k7_gy_r;
  logic signed [W+F+6:0] gxp, gyp;
  logic             wclip;

  assign gxp   = k6_g_r * k6_ux_r;
  assign gyp   = k6_g_r * k6_uy_r;
  assign wclip = |k6_w_r[W+3:W];

  always_ff @(posedge clk) begin
    if (!rst_n) k7_v_r <= 1'b0;
    else if (en) k7_v_r <= k6_v_r;
    if (en) begin
      k7_out_r   <= k6_out_r;
      k7_nz_r    <= k6_nz_r;
      k7_wclip_r <= wclip;
      k7_w_r     <= wclip ? '1 : k6_w_r[W-1:0];
      k7_gx_r    <= gxp[W+F+6:F];
      k7_gy_r    <= gyp[W+F+6:F];
    end
  end

  // K8: gradient saturation, special cases and the output register.
  logic [W-1:0]  k8_w_r, k8_gx_r, k8_gy_r;
  logic          k8_out_r, k8_sat_r;
  logic          ovx, ovy;
  logic [W-1:0]  gx_sat, gy_sat, w_nxt, gx_nxt, gy_nxt;
  logic          sat_nxt;

  always_comb begin
    ovx    = !((&k7_gx_r[W+6:W-1]) || !(|k7_gx_r[W+6:W-1]));
    ovy    = !((&k7_gy_r[W+6:W-1]) || !(|k7_gy_r[W+6:W-1]));
    gx_sat = ovx ? {k7_gx_r[W+6], {(W-1){!k7_gx_r[W+6]}}} : k7_gx_r[W-1:0];
    gy_sat = ovy ? {k7_gy_r[W+6], {(W-1){!k7_gy_r[W+6]}}} : k7_gy_r[W-1:0];
    w_nxt   = '0;
    gx_nxt  = '0;
    gy_nxt  = '0;
    sat_nxt = 1'b0;
    if (!k7_out_r) begin
      w_nxt   = k7_w_r;
      sat_nxt = k7_wclip_r;
      if (k7_nz_r) begin
        gx_nxt  = gx_sat;
        gy_nxt  = gy_sat;
        sat_nxt = k7_wclip_r || ovx || ovy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) k8_v_r <= 1'b0;
    else if (en) k8_v_r <= k7_v_r;
    if (en) begin
      k8_w_r   <= w_nxt;
      k8_gx_r  <= gx_nxt;
      k8_gy_r  <= gy_nxt;
      k8_out_r <= k7_out_r;
      k8_sat_r <= sat_nxt;
    end
  end

  assign out_valid           = k8_v_r;
  assign out_kernel_value    = k8_w_r;
  assign out_grad_x          = $signed(k8_gx_r);
  assign out_grad_y          = $signed(k8_gy_r);
  assign out_outside_support = k8_out_r;
  assign out_saturated       = k8_sat_r;

endmodule
